/* sv/qrt_pkg.sv */
`default_nettype none

package qrt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EXP,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_ACC_SQ,
    SEL_SQ_SQ,
    SEL_ACC_ACC
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     mul_run;
    logic     shift_e;
  } dp_cmd_t;

  typedef struct packed {
    logic oor;
    logic e_zero;
    logic e_lsb;
    logic mul_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/qrt_ctrl.sv */
`default_nettype none

module qrt_ctrl
  import qrt_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = status.oor ? ST_DONE : ST_EXP;
      end
      ST_EXP: begin
        if (status.e_zero) begin
          state_nxt = ST_FINAL;
        end else if (status.e_lsb) begin
          state_nxt = ST_MUL_ACC;
        end else begin
          state_nxt = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        if (status.mul_last) begin
          state_nxt = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (status.mul_last) begin
          state_nxt = ST_EXP;
        end
      end
      ST_FINAL: begin
        if (status.mul_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = SEL_SQ_SQ;
    busy      = 1'b1;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CHECK: begin
      end
      ST_EXP: begin
        cmd.mul_start = 1'b1;
        if (status.e_zero) begin
          cmd.mul_sel = SEL_ACC_ACC;
        end else if (status.e_lsb) begin
          cmd.mul_sel = SEL_ACC_SQ;
        end else begin
          cmd.mul_sel = SEL_SQ_SQ;
        end
      end
      ST_MUL_ACC: begin
        cmd.mul_run   = 1'b1;
        cmd.mul_start = status.mul_last;
        cmd.mul_sel   = SEL_SQ_SQ;
      end
      ST_MUL_SQ: begin
        cmd.mul_run = 1'b1;
        cmd.shift_e = status.mul_last;
      end
      ST_FINAL: begin
        cmd.mul_run = 1'b1;
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/qrt_dp.sv */
`default_nettype none

module qrt_dp
  import qrt_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire [VALUE_BITS-1:0]   cfg_wdata,
  input  wire [VALUE_BITS-1:0]   in_value,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic                   is_residue,
  output logic                   out_of_range
);

  localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] mod_r;
  logic [VALUE_BITS-1:0] v_r;
  logic [VALUE_BITS-1:0] acc_r;
  logic [VALUE_BITS-1:0] sq_r;
  logic [VALUE_BITS-1:0] e_r;
  logic [VALUE_BITS-1:0] ma_r;
  logic [VALUE_BITS-1:0] mb_r;
  logic [VALUE_BITS-1:0] mp_r;
  logic [CNT_BITS-1:0]   cnt_r;
  mul_sel_t              sel_r;

  logic [VALUE_BITS:0]   e_init;
  logic [VALUE_BITS:0]   dbl;
  logic [VALUE_BITS:0]   dbl_red;
  logic [VALUE_BITS:0]   add;
  logic [VALUE_BITS:0]   add_red;
  logic [VALUE_BITS-1:0] step_res;
  logic [VALUE_BITS-1:0] op_a;
  logic [VALUE_BITS-1:0] op_b;
  logic                  mul_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= VALUE_BITS'(3);
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  assign e_init = ({1'b0, mod_r} + {{VALUE_BITS{1'b0}}, 1'b1}) >> 2;

  always_comb begin
    op_a = acc_r;
    op_b = sq_r;
    case (cmd.mul_sel)
      SEL_ACC_SQ: begin
        op_a = acc_r;
        op_b = sq_r;
      end
      SEL_SQ_SQ: begin
        op_a = sq_r;
        op_b = sq_r;
      end
      SEL_ACC_ACC: begin
        op_a = acc_r;
        op_b = acc_r;
      end
      default: begin
        op_a = acc_r;
        op_b = sq_r;
      end
    endcase
  end

  // One bit of the multiplier per cycle, most significant first, reduced twice.
  always_comb begin
    dbl     = {mp_r, 1'b0};
    dbl_red = (dbl >= {1'b0, mod_r}) ? dbl - {1'b0, mod_r} : dbl;
    add     = dbl_red + (mb_r[cnt_r] ? {1'b0, ma_r} : '0);
    add_red = (add >= {1'b0, mod_r}) ? add - {1'b0, mod_r} : add;
    step_res = add_red[VALUE_BITS-1:0];
  end

  assign mul_last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r   <= in_value;
      sq_r  <= in_value;
      acc_r <= (mod_r == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);
      e_r   <= e_init[VALUE_BITS-1:0];
    end else begin
      if (cmd.mul_run && mul_last) begin
        if (sel_r == SEL_SQ_SQ) begin
          sq_r <= step_res;
        end else begin
          acc_r <= step_res;
        end
      end
      if (cmd.shift_e) begin
        e_r <= e_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_r  <= op_a;
      mb_r  <= op_b;
      mp_r  <= '0;
      cnt_r <= CNT_BITS'(VALUE_BITS - 1);
      sel_r <= cmd.mul_sel;
    end else if (cmd.mul_run) begin
      mp_r  <= step_res;
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  assign status.oor      = (v_r >= mod_r);
  assign status.e_zero   = (e_r == '0);
  assign status.e_lsb    = e_r[0];
  assign status.mul_last = mul_last;

  assign out_of_range = status.oor;
  assign is_residue   = !status.oor && (acc_r == v_r);

endmodule

`default_nettype wire

/* sv/quadratic_residue_test_core.sv */
`default_nettype none

// Channel  Handshake                Data
// input    start / busy             in_value
// result   out_strobe (one cycle)   out_is_residue, out_out_of_range
// config   cfg_we                   cfg_wdata
//
// An item's run time is set by the bit-serial modular multiplier (one operand bit per cycle),
// which raises the value to the power (modulus + 1) / 4.
// An out-of-range item skips the exponentiation and goes from the check straight to the strobe.
// Reset is synchronous and sets the modulus to 3.
// The result cannot be stalled; busy stays high until the strobe cycle ends.

module quadratic_residue_test_core
  import qrt_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire [VALUE_BITS-1:0] in_value,
  output logic                 out_strobe,
  output logic                 out_is_residue,
  output logic                 out_out_of_range,
  input  wire                  cfg_we,
  input  wire [VALUE_BITS-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  qrt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_strobe)
  );

  qrt_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_value     (in_value),
    .cmd          (cmd),
    .status       (status),
    .is_residue   (out_is_residue),
    .out_of_range (out_out_of_range)
  );

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_is_residue && out_out_of_range))
    else $error("residue and out-of-range flags both set");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!busy && !out_strobe))
    else $error("block not idle after result strobe");
`endif

endmodule

`default_nettype wire

/* test/quadratic_residue_test_core_tb.sv */
`timescale 1ns / 1ps

module quadratic_residue_test_core_tb;

  localparam int VALUE_BITS  = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_WORDS = 75;
  localparam int PHASES      = 10;

  typedef enum bit {
    KIND_WORD,
    KIND_MODULUS
  } entry_kind_t;

  typedef struct {
    entry_kind_t           kind;
    bit [VALUE_BITS-1:0]   data;
    bit                    quiet;
  } send_entry_t;

  typedef struct packed {
    logic is_residue;
    logic out_of_range;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  cfg_we = 1'b0;
  logic [VALUE_BITS-1:0] cfg_wdata = '0;
  wire                   busy;
  wire                   out_strobe;
  wire                   out_is_residue;
  wire                   out_out_of_range;

  send_entry_t           words_to_send[$];
  verdict_t              awaited_verdicts[$];
  bit [VALUE_BITS-1:0]   modulus_copy = 3;
  int unsigned           gap_left = 0;
  bit                    gaps_on = 1'b1;
  bit                    mismatch = 1'b0;
  int unsigned           cycle_count = 0;

  quadratic_residue_test_core #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .out_strobe(out_strobe),
    .out_is_residue(out_is_residue),
    .out_out_of_range(out_out_of_range),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The candidate root is v^((m+1)/4) mod m; v is a residue when the root squares back to v.
  function automatic verdict_t residue_verdict(bit [VALUE_BITS-1:0] v,
                                               bit [VALUE_BITS-1:0] m);
    verdict_t           vd;
    bit [2*VALUE_BITS-1:0] acc;
    bit [2*VALUE_BITS-1:0] sq;
    bit [VALUE_BITS:0]     e;
    vd = '0;
    if (v >= m) begin
      vd.out_of_range = 1'b1;
      return vd;
    end
    e   = ({1'b0, m} + 1'b1) >> 2;
    acc = 1 % m;
    sq  = v % m;
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * sq) % m;
      end
      sq = (sq * sq) % m;
      e  = e >> 1;
    end
    vd.is_residue = (((acc * acc) % m) == v);
    return vd;
  endfunction

  task automatic queue_word(bit [VALUE_BITS-1:0] v, bit quiet);
    send_entry_t e;
    e.kind  = KIND_WORD;
    e.data  = v;
    e.quiet = quiet;
    words_to_send.push_back(e);
  endtask

  task automatic queue_modulus(bit [VALUE_BITS-1:0] m);
    send_entry_t e;
    e.kind  = KIND_MODULUS;
    e.data  = m;
    e.quiet = 1'b0;
    words_to_send.push_back(e);
  endtask

  function automatic bit [VALUE_BITS-1:0] random_word(int unsigned m);
    longint unsigned x;
    x = $urandom_range(0, 65535);
    case ($urandom_range(0, 9))
      0, 1: return VALUE_BITS'($urandom_range(0, 65535));
      2: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return VALUE_BITS'(m);
          default: return (m == 0) ? '0 : VALUE_BITS'(m - 1);
        endcase
      end
      3, 4, 5: return (m == 0) ? VALUE_BITS'(x) : VALUE_BITS'((x * x) % m);
      default: return (m == 0) ? VALUE_BITS'(x) : VALUE_BITS'($urandom_range(0, m - 1));
    endcase
  endfunction

  always @(posedge clk) begin : driver
    logic        next_start;
    logic        next_we;
    send_entry_t head;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      modulus_copy = 3;
      gap_left = 0;
    end else begin
      next_start = start;
      next_we = 1'b0;
      if (start && !busy) begin
        awaited_verdicts.push_back(residue_verdict(in_value, modulus_copy));
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (words_to_send.size() != 0) begin
          head = words_to_send[0];
          if (head.kind == KIND_WORD) begin
            if (!head.quiet && gaps_on && $urandom_range(0, 2) == 0) begin
              gap_left = $urandom_range(1, 5);
            end else begin
              next_start = 1'b1;
              in_value <= head.data;
              void'(words_to_send.pop_front());
              if ($urandom_range(0, 39) == 0) begin
                gaps_on = !gaps_on;
              end
            end
          end else if (awaited_verdicts.size() == 0 && !busy && !start) begin
            next_we = 1'b1;
            cfg_wdata <= head.data;
            modulus_copy = head.data;
            void'(words_to_send.pop_front());
          end
        end
      end
      start <= next_start;
      cfg_we <= next_we;
    end
  end

  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst_n && out_strobe) begin
      if (awaited_verdicts.size() == 0) begin
        $error("Result word arrived with no expectation pending.");
        mismatch = 1'b1;
      end else begin
        want = awaited_verdicts.pop_front();
        if (out_is_residue !== want.is_residue) begin
          $error("is_residue mismatch: expected %0b, actual %0b",
                 want.is_residue, out_is_residue);
          mismatch = 1'b1;
        end
        if (out_out_of_range !== want.out_of_range) begin
          $error("out_of_range mismatch: expected %0b, actual %0b",
                 want.out_of_range, out_out_of_range);
          mismatch = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_moduli[PHASES];
    int unsigned m;
    bit          quiet;

    // The reset modulus of three is exercised before any write.
    queue_word(0, 1'b0);
    queue_word(1, 1'b0);
    queue_word(2, 1'b0);
    queue_word(3, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_modulus(0);
    queue_word(0, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_modulus(1);
    queue_word(0, 1'b0);
    queue_word(1, 1'b0);
    queue_modulus(2);
    queue_word(0, 1'b0);
    queue_word(1, 1'b0);
    queue_word(2, 1'b0);
    queue_modulus(65519);
    queue_word(0, 1'b0);
    queue_word(1, 1'b0);
    queue_word(4, 1'b0);
    queue_word(65518, 1'b0);
    queue_word(65519, 1'b0);
    queue_modulus(16'hFFFF);
    queue_word(65534, 1'b0);
    queue_word(16'hFFFF, 1'b0);

    phase_moduli = '{65519, 0, 1, 2, 65535, 3,
                     $urandom_range(0, 16383) * 4 + 3,
                     $urandom_range(0, 65535), 7, 65519};
    for (int p = 0; p < PHASES; p++) begin
      m = phase_moduli[p];
      quiet = (p == PHASES - 1);
      queue_modulus(VALUE_BITS'(m));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        queue_word(random_word(m), quiet);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() != 0 || start || awaited_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (!mismatch && awaited_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* quadratic_residue_test_core.f */
sv/qrt_pkg.sv
sv/qrt_ctrl.sv
sv/qrt_dp.sv
sv/quadratic_residue_test_core.sv
test/quadratic_residue_test_core_tb.sv
